// ===== rtl/core/sat_pkg.sv =====
// ============================================================================
// sat_pkg: shared definitions of the sorted alarm timer queue
// Sizes, request and status codes, the slot entry and the cell control word.
// ============================================================================
package sat_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int ALARM_KINDS = 4;
    localparam int OWNER_COUNT = 256;
    localparam int MAX_RESULTS = 16;

    localparam int REQ_W    = 2;
    localparam int TIME_W   = 32;
    localparam int OWNER_W  = 8;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEREGISTER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK       = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOREG = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0]  due;
        logic [OWNER_W-1:0] owner;
        logic [KIND_W-1:0]  kind;
    } slot_entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DROP,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [TIME_W-1:0]  due;
        logic [OWNER_W-1:0] owner;
        logic [KIND_W-1:0]  kind;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_INSERT,
        ST_TICK
    } sat_state_t;

endpackage

// ===== rtl/core/sat_req_if.sv =====
// ============================================================================
// sat_req_if: request channel of the alarm timer queue
// Valid/ready handshake carrying one alarm request.
// ============================================================================
interface sat_req_if;
    import sat_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  delay_ms;
    logic [OWNER_W-1:0] owner;
    logic [KIND_W-1:0]  alarm_kind;

    modport source (output valid, req_type, now_ms, delay_ms, owner, alarm_kind,
                    input ready);
    modport sink   (input valid, req_type, now_ms, delay_ms, owner, alarm_kind,
                    output ready);
endinterface

// ===== rtl/core/sat_rsp_if.sv =====
// ============================================================================
// sat_rsp_if: result channel of the alarm timer queue
// Valid/ready handshake carrying one result of a request.
// ============================================================================
interface sat_rsp_if;
    import sat_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [OWNER_W-1:0]  fired_owner;
    logic [KIND_W-1:0]   fired_kind;
    logic                last;

    modport source (output valid, status, fired, fired_owner, fired_kind, last,
                    input ready);
    modport sink   (input valid, status, fired, fired_owner, fired_kind, last,
                    output ready);
endinterface

// ===== rtl/core/sorted_alarm_timer_queue_unit.sv =====
// ============================================================================
// sorted_alarm_timer_queue_unit: sorted queue of pending alarms
// A chain of slot cells keeps alarms in due order; a small sequencer runs it.
// ============================================================================
// Usage. Requests arrive on the req channel and results leave on the rsp
// channel, both valid/ready. A register request stores an alarm due at
// now_ms + delay_ms (saturating) behind any alarm with the same due time and
// replaces an older entry of the same owner and kind. A deregister request
// removes that pair. Both give one result with last set. A tick request
// emits one result per alarm due at or before now_ms, up to MAX_RESULTS,
// earliest first, last set on the final one; none due gives one empty result.
//
// Sequencing. The sequencer works on one request at a time. A register
// request passes through accept, match and drop, then insert; a deregister
// or unknown request through accept and match; a tick through accept, then
// one result step per alarm it fires (at least one). It fires one alarm per
// cycle unless the receiver stalls, as each pop shifts the whole cell chain.
//
// Reset clears every slot's valid bit at once, so the queue is empty right
// after reset. Results go through a one-entry output register; when the
// receiver stalls, the sequencer holds its step until the register frees,
// and the next request is taken while a last result still waits.
// ============================================================================
module sorted_alarm_timer_queue_unit (
    input logic  clk,
    input logic  rst_n,
    sat_req_if.sink   req,
    sat_rsp_if.source rsp
);
    import sat_pkg::*;

    localparam int N = TIMER_SLOTS;

    sat_state_t         state_reg, state_next;
    logic [REQ_W-1:0]   type_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  due_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                fired_reg;
    logic [OWNER_W-1:0]  fired_owner_reg;
    logic [KIND_W-1:0]   fired_kind_reg;
    logic                last_reg;

    logic [TIME_W:0]     due_sum;
    logic [TIME_W-1:0]   due_sat;
    logic                accept;
    logic                space;
    logic                in_range;
    logic                any_match;
    logic                full;
    logic                pop_ok;
    logic                tick_last;

    // Sequencer outputs.
    cell_ctrl_t          ctrl;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_fired;
    logic                emit_last;

    slot_entry_t         entry_vec [N];
    logic [N:0]          past;
    logic [N-1:0]        open_vec;
    logic [N-1:0]        valid_vec;

    // ------------------------------------------------------------------
    // Cell chain: slot 0 holds the earliest alarm.
    // ------------------------------------------------------------------
    assign past[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        slot_entry_t left_e;
        slot_entry_t right_e;
        logic        ins_in;

        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign ins_in = 1'b0;
        end
        else
        begin : g_body
            assign left_e = entry_vec[i-1];
            assign ins_in = open_vec[i-1];
        end

        if (i == N - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = entry_vec[i+1];
        end

        sat_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_e),
            .right     (right_e),
            .past_in   (past[i]),
            .ins_in    (ins_in),
            .entry     (entry_vec[i]),
            .past_out  (past[i+1]),
            .open_slot (open_vec[i])
        );

        assign valid_vec[i] = entry_vec[i].valid;
    end

    assign any_match = past[N];
    assign full      = entry_vec[N-1].valid;

    // ------------------------------------------------------------------
    // Request capture. The due time saturates at the largest count.
    // ------------------------------------------------------------------
    assign accept  = req.valid && req.ready;
    assign due_sum = {1'b0, req.now_ms} + {1'b0, req.delay_ms};
    assign due_sat = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= req.req_type;
            now_reg   <= req.now_ms;
            due_reg   <= due_sat;
            owner_reg <= req.owner;
            kind_reg  <= req.alarm_kind;
        end
    end

    assign in_range = (int'(owner_reg) < OWNER_COUNT) && (int'(kind_reg) < ALARM_KINDS);

    // The output register can take a result this cycle.
    assign space = !out_valid_reg || rsp.ready;

    // A tick fires the head alarm when it is due; it is the last one when the
    // result budget runs out or the next alarm is not due.
    assign pop_ok    = entry_vec[0].valid && (entry_vec[0].due <= now_reg);
    assign tick_last = (cnt_reg == CNT_W'(MAX_RESULTS - 1)) ||
                       !(entry_vec[1].valid && (entry_vec[1].due <= now_reg));

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.req_type == REQ_TICK) ? ST_TICK : ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (space)
                begin
                    state_next = ((type_reg == REQ_REGISTER) && in_range) ? ST_INSERT
                                                                           : ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                if (space)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (space && (!pop_ok || tick_last))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs (cell command and result).
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl        = '{op: CELL_HOLD, due: due_reg, owner: owner_reg, kind: kind_reg};
        emit        = 1'b0;
        emit_status = STATUS_OK;
        emit_fired  = 1'b0;
        emit_last   = 1'b1;
        case (state_reg)
            ST_MATCH:
            begin
                if (space)
                begin
                    if (type_reg == REQ_REGISTER)
                    begin
                        // An existing entry of the pair is dropped before inserting.
                        if (in_range)
                        begin
                            ctrl.op = CELL_DROP;
                        end
                        else
                        begin
                            emit        = 1'b1;
                            emit_status = STATUS_NOREG;
                        end
                    end
                    else if (type_reg == REQ_DEREGISTER)
                    begin
                        emit = 1'b1;
                        if (in_range && any_match)
                        begin
                            ctrl.op = CELL_DROP;
                        end
                        else
                        begin
                            emit_status = STATUS_NOREG;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            ST_INSERT:
            begin
                if (space)
                begin
                    emit = 1'b1;
                    if (full)
                    begin
                        emit_status = STATUS_FULL;
                    end
                    else
                    begin
                        ctrl.op = CELL_INSERT;
                    end
                end
            end
            ST_TICK:
            begin
                if (space)
                begin
                    emit = 1'b1;
                    if (pop_ok)
                    begin
                        ctrl.op    = CELL_POP;
                        emit_fired = 1'b1;
                        emit_last  = tick_last;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.op == CELL_POP)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The fired alarm is taken from the head slot before the chain shifts.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg      <= emit_status;
            fired_reg       <= emit_fired;
            fired_owner_reg <= emit_fired ? entry_vec[0].owner : '0;
            fired_kind_reg  <= emit_fired ? entry_vec[0].kind : '0;
            last_reg        <= emit_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.fired       = fired_reg;
    assign rsp.fired_owner = fired_owner_reg;
    assign rsp.fired_kind  = fired_kind_reg;
    assign rsp.last        = last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Valid slots stay packed at the low end of the chain.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + N'(1)) & valid_vec) == '0)
        else $error("valid slots are not packed");

    // An insert into a chain that is not full always finds a free slot.
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT && space && !full) |-> open_vec[N-1])
        else $error("insert found no slot");

    // Each pop removes exactly one alarm.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == CELL_POP) |=> ($countones(valid_vec) == $past($countones(valid_vec)) - 1))
        else $error("pop did not remove one alarm");

    // A fired result always carries the ok status.
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fired_reg) |-> (status_reg == STATUS_OK))
        else $error("fired result with error status");

endmodule

// ===== rtl/core/sat_cell.sv =====
// ============================================================================
// sat_cell: one slot of the sorted alarm chain
// Holds one alarm and moves it to or from its neighbors on drop, insert, pop.
// ============================================================================
module sat_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sat_pkg::cell_ctrl_t  ctrl,
    input  sat_pkg::slot_entry_t left,
    input  sat_pkg::slot_entry_t right,
    input  logic                 past_in,
    input  logic                 ins_in,
    output sat_pkg::slot_entry_t entry,
    output logic                 past_out,
    output logic                 open_slot
);
    import sat_pkg::*;

    logic               valid_reg, valid_next;
    logic [TIME_W-1:0]  due_reg, due_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               match;

    assign match     = valid_reg && (owner_reg == ctrl.owner) && (kind_reg == ctrl.kind);
    assign past_out  = past_in || match;
    // The new alarm goes in front of the first later alarm or into the first free slot.
    assign open_slot = !valid_reg || (due_reg > ctrl.due);

    always_comb
    begin
        valid_next = valid_reg;
        due_next   = due_reg;
        owner_next = owner_reg;
        kind_next  = kind_reg;
        case (ctrl.op)
            CELL_DROP:
            begin
                if (past_out)
                begin
                    valid_next = right.valid;
                    due_next   = right.due;
                    owner_next = right.owner;
                    kind_next  = right.kind;
                end
            end
            CELL_POP:
            begin
                valid_next = right.valid;
                due_next   = right.due;
                owner_next = right.owner;
                kind_next  = right.kind;
            end
            CELL_INSERT:
            begin
                if (ins_in)
                begin
                    valid_next = left.valid;
                    due_next   = left.due;
                    owner_next = left.owner;
                    kind_next  = left.kind;
                end
                else if (open_slot)
                begin
                    valid_next = 1'b1;
                    due_next   = ctrl.due;
                    owner_next = ctrl.owner;
                    kind_next  = ctrl.kind;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        due_reg   <= due_next;
        owner_reg <= owner_next;
        kind_reg  <= kind_next;
    end

    assign entry = '{valid: valid_reg, due: due_reg, owner: owner_reg, kind: kind_reg};

endmodule
